// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin task table scheduler:
// request and status codes, stream widths and the default table depth.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

    // default number of task slots
    localparam int NUM_SLOTS_DEF = 16;

    // field widths fixed by the stream format
    localparam int REQ_W       = 2;
    localparam int SP_W        = 64;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;

    // stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SLOT_OUT_W - SP_W - COUNT_OUT_W - 1;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_SWITCH = 2'd1,
        REQ_EXIT   = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOSWITCH = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/round_robin_task_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_table_scheduler
// Task table with round-robin selection. Saved stack pointers sit in a
// one-port synchronous memory; slot liveness is kept as a bit per slot.
// ----------------------------------------------------------------------------
// Sequence: create, exit, unknown and inactive switch go straight to the hold state
// after the beat is taken; an active switch first scans one slot per cycle, visiting
// 1 to NUM_SLOTS slots up to its hit, then does one pointer read before the hold.
// Throughput: one request in flight; the next beat is taken once the result moves
// to the output register, where it may wait for the receiver.
// Reset: slot 0 running, live count 1, switching off; pointer memory not cleared.
`default_nettype none

module round_robin_task_table_scheduler #(
    parameter int NUM_SLOTS = rrts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: [63:0] stack_ptr_in
    input  wire logic [rrts_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: [1:0] req_type
    input  wire logic [rrts_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,
    // master side
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // tdata: [3:0] slot_out, [67:4] stack_ptr_out, [72:68] live_count,
    //        [73] switching_on, [79:74] zero
    output logic [rrts_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // tuser: [1:0] status
    output logic [rrts_pkg::OUT_TUSER_W-1:0]      o_m_axis_tuser
);

    import rrts_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_HOLD
    } t_state;

    t_state                r_state;
    logic [NUM_SLOTS-1:0]  r_live;
    logic [SLOT_W-1:0]     r_cur;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_next_free;
    logic                  r_enabled;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_scan_cnt;
    logic [SP_W-1:0]       r_sp;

    // pending result
    t_status               r_pnd_status;
    logic [SLOT_W-1:0]     r_pnd_slot;
    logic [SP_W-1:0]       r_pnd_sp;

    // output register
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TUSER_W-1:0] r_out_user;

    // stack pointer memory
    logic [SP_W-1:0]       r_sp_mem [NUM_SLOTS];
    logic [SP_W-1:0]       r_rd_data;

    logic                  w_acc;
    t_req                  w_req;
    logic [SP_W-1:0]       w_sp_in;
    logic                  w_full;
    logic                  w_sw_off;
    logic [SLOT_W-1:0]     w_idx_next;
    logic [SLOT_W-1:0]     w_cur_next;
    logic [SLOT_W-1:0]     w_free_slot;
    logic                  w_mem_we;
    logic [SLOT_W-1:0]     w_mem_waddr;
    logic                  w_mem_re;
    logic                  w_out_free;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_slot_wide;
    logic [CNT_W+COUNT_OUT_W-1:0] w_cnt_wide;

    // decode the incoming beat
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_acc       = i_s_axis_tvalid && (r_state == S_IDLE);
    assign w_req       = t_req'(i_s_axis_tuser[REQ_W-1:0]);
    assign w_sp_in     = i_s_axis_tdata[SP_W-1:0];
    assign w_full      = (r_count >= CNT_FULL) || (r_next_free == CNT_FULL);
    assign w_sw_off    = !r_enabled || (r_count < CNT_W'(2));
    assign w_free_slot = r_next_free[SLOT_W-1:0];

    // cyclic successors
    assign w_idx_next = (r_idx == LAST_SLOT) ? '0 : r_idx + SLOT_W'(1);
    assign w_cur_next = (r_cur == LAST_SLOT) ? '0 : r_cur + SLOT_W'(1);

    // memory port control: write on accept, read when the scan hits
    assign w_mem_we    = w_acc && (((w_req == REQ_CREATE) && !w_full) ||
                                   ((w_req == REQ_SWITCH) && !w_sw_off));
    assign w_mem_waddr = (w_req == REQ_CREATE) ? w_free_slot : r_cur;
    assign w_mem_re    = (r_state == S_SCAN) && r_live[r_idx];

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // fit slot and count to the fixed output widths
    assign w_slot_wide = {{SLOT_OUT_W{1'b0}}, r_pnd_slot};
    assign w_cnt_wide  = {{COUNT_OUT_W{1'b0}}, r_count};

    // stack pointer memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_sp_mem[w_mem_waddr] <= w_sp_in;
        end
        if (w_mem_re) begin
            r_rd_data <= r_sp_mem[r_idx];
        end
    end

    // sequencer, task table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= NUM_SLOTS'(1);
            r_cur       <= '0;
            r_count     <= CNT_W'(1);
            r_next_free <= CNT_W'(1);
            r_enabled   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output beat once taken
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_sp         <= w_sp_in;
                        r_pnd_status <= STAT_OK;
                        r_pnd_slot   <= r_cur;
                        r_pnd_sp     <= '0;
                        r_state      <= S_HOLD;
                        case (w_req)
                            REQ_CREATE: begin
                                if (w_full) begin
                                    r_pnd_status <= STAT_FULL;
                                    r_pnd_slot   <= '0;
                                end else begin
                                    r_live[w_free_slot] <= 1'b1;
                                    r_next_free <= r_next_free + CNT_W'(1);
                                    r_count     <= r_count + CNT_W'(1);
                                    if (r_count >= CNT_W'(1)) begin
                                        r_enabled <= 1'b1;
                                    end
                                    r_pnd_slot <= w_free_slot;
                                end
                            end
                            REQ_SWITCH: begin
                                if (w_sw_off) begin
                                    r_pnd_status <= STAT_NOSWITCH;
                                    r_pnd_sp     <= w_sp_in;
                                end else begin
                                    // pointer saved via memory port; start scan
                                    r_idx      <= w_cur_next;
                                    r_scan_cnt <= '0;
                                    r_state    <= S_SCAN;
                                end
                            end
                            REQ_EXIT: begin
                                if (r_live[r_cur] && (r_count != '0)) begin
                                    r_live[r_cur] <= 1'b0;
                                    r_count       <= r_count - CNT_W'(1);
                                end
                            end
                            default: begin
                                // unknown request: report current slot only
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    // visit one slot a cycle, current slot last
                    if (r_live[r_idx]) begin
                        r_cur      <= r_idx;
                        r_pnd_slot <= r_idx;
                        r_state    <= S_READ;
                    end else if (r_scan_cnt == LAST_SLOT) begin
                        r_pnd_status <= STAT_NOSWITCH;
                        r_pnd_sp     <= r_sp;
                        r_state      <= S_HOLD;
                    end else begin
                        r_idx      <= w_idx_next;
                        r_scan_cnt <= r_scan_cnt + SLOT_W'(1);
                    end
                end

                S_READ: begin
                    // capture the restored pointer
                    r_pnd_sp <= r_rd_data;
                    r_state  <= S_HOLD;
                end

                S_HOLD: begin
                    // load the output register when it frees up
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= OUT_TUSER_W'(r_pnd_status);
                        r_out_data  <= {{OUT_PAD_W{1'b0}}, r_enabled,
                                        w_cnt_wide[COUNT_OUT_W-1:0], r_pnd_sp,
                                        w_slot_wide[SLOT_OUT_W-1:0]};
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // live count tracks the live bits
    a_count_matches_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_live) == int'(r_count))
        else $error("live count differs from number of live slots");

    // switching never turns off once on
    a_enabled_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_enabled |=> r_enabled)
        else $error("switching flag cleared");

    // current task always lies in an allocated slot
    a_cur_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_cur) < r_next_free)
        else $error("current slot beyond allocated slots");

    // the slot chosen by the scan is live while its pointer is read
    a_read_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> r_live[r_cur])
        else $error("switched to a slot that is not live");

endmodule

`default_nettype wire
